// ===== hw/rtl/double_ended_queue_top_macros.svh =====
// Assertion macros shared by the double-ended queue RTL.
`ifndef DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Plain property checked on every clock edge outside reset.
`define DEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Same-cycle implication checked on every clock edge outside reset.
`define DEQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked on every clock edge outside reset.
`define DEQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DEQ_ASSERT(lbl, prop, msg)
`define DEQ_ASSERT_IMP(lbl, ante, cons, msg)
`define DEQ_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/deq_pkg.sv =====
// Package with sizes, opcodes, state type and index helpers for the deque.
package deq_pkg;

  // Storage geometry.
  localparam int CAPACITY  = 256;
  localparam int WORD_BITS = 32;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int OP_BITS   = 3;

  // Opcodes carried by each input beat; codes 6 and 7 act as a query.
  typedef enum logic [OP_BITS-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_CLEAR      = 3'd4,
    OP_QUERY      = 3'd5
  } op_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_LOAD = 2'd2
  } state_e;

  // Circular increment of a slot index.
  function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    r = (i == IDX_W'(CAPACITY - 1)) ? '0 : i + IDX_W'(1);
    return r;
  endfunction

  // Circular decrement of a slot index.
  function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    r = (i == '0) ? IDX_W'(CAPACITY - 1) : i - IDX_W'(1);
    return r;
  endfunction

endpackage

// ===== hw/rtl/double_ended_queue_top.sv =====
// Double-ended queue of words held in one circular synchronous memory.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------------------
//   in      | input     | in_valid_i/in_stall_o | in_opcode_i, in_push_word_i
//   out     | output    | out_valid_o/out_stall_i | front/back word, occupancy, flags, error
//
// For each input beat the accept cycle updates the indices and writes the memory, the
// next cycle reads the front and back slots through the two read ports, and the result
// register is then loaded once the output register is free; the input stalls until then.
// Reset clears the indices, the count and the result valid; memory contents stay
// undefined and are never shown before being written. A stalled result waits in the
// output register while the next input beat is already taken.
module double_ended_queue_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [deq_pkg::OP_BITS-1:0]     in_opcode_i,
  input  logic [deq_pkg::WORD_BITS-1:0]   in_push_word_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [deq_pkg::WORD_BITS-1:0]   out_front_word_o,
  output logic [deq_pkg::WORD_BITS-1:0]   out_back_word_o,
  output logic [deq_pkg::CNT_W-1:0]       out_occupancy_o,
  output logic                            out_is_empty_o,
  output logic                            out_is_full_o,
  output logic                            out_op_error_o
);
  import deq_pkg::*;
  `include "double_ended_queue_top_macros.svh"

  state_e state_q, state_d;

  logic [IDX_W-1:0] head_q, head_d;
  logic [IDX_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             err_q, err_d;

  logic             in_accept;
  logic             wr_en;
  logic             rd_en;
  logic             res_load;
  logic [IDX_W-1:0] wr_addr;
  logic             q_full;
  logic             q_empty;
  op_e              op;

  logic [WORD_BITS-1:0] store_q [CAPACITY];
  logic [WORD_BITS-1:0] rd_front_q;
  logic [WORD_BITS-1:0] rd_back_q;

  logic                 out_valid_q;
  logic [WORD_BITS-1:0] front_q;
  logic [WORD_BITS-1:0] back_q;
  logic [CNT_W-1:0]     occ_q;
  logic                 empty_q;
  logic                 full_q;
  logic                 operr_q;

  // Control outputs of the sequencer.
  always_comb begin
    in_stall_o = 1'b1;
    rd_en      = 1'b0;
    res_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      ST_READ: begin
        rd_en = 1'b1;
      end
      ST_LOAD: begin
        res_load = !out_valid_q || !out_stall_i;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  assign in_accept = in_valid_i && !in_stall_o;

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) state_d = ST_READ;
      end
      ST_READ: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (res_load) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Index, count and error updates for an accepted beat.
  assign op      = op_e'(in_opcode_i);
  assign q_full  = (cnt_q == CNT_W'(CAPACITY));
  assign q_empty = (cnt_q == '0);

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    cnt_d   = cnt_q;
    err_d   = err_q;
    wr_en   = 1'b0;
    wr_addr = tail_q;
    if (in_accept) begin
      err_d = 1'b0;
      unique case (op)
        OP_PUSH_FRONT: begin
          if (q_full) begin
            err_d = 1'b1;
          end else begin
            head_d  = idx_prev(head_q);
            wr_addr = idx_prev(head_q);
            wr_en   = 1'b1;
            cnt_d   = cnt_q + CNT_W'(1);
          end
        end
        OP_PUSH_BACK: begin
          if (q_full) begin
            err_d = 1'b1;
          end else begin
            wr_addr = tail_q;
            wr_en   = 1'b1;
            tail_d  = idx_next(tail_q);
            cnt_d   = cnt_q + CNT_W'(1);
          end
        end
        OP_POP_FRONT: begin
          if (q_empty) begin
            err_d = 1'b1;
          end else begin
            head_d = idx_next(head_q);
            cnt_d  = cnt_q - CNT_W'(1);
          end
        end
        OP_POP_BACK: begin
          if (q_empty) begin
            err_d = 1'b1;
          end else begin
            tail_d = idx_prev(tail_q);
            cnt_d  = cnt_q - CNT_W'(1);
          end
        end
        OP_CLEAR: begin
          head_d = '0;
          tail_d = '0;
          cnt_d  = '0;
        end
        default: begin
          err_d = 1'b0;
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      cnt_q   <= '0;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
      err_q   <= err_d;
    end
  end

  // Word memory: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_addr] <= in_push_word_i;
    end
    if (rd_en) begin
      rd_front_q <= store_q[head_q];
      rd_back_q  <= store_q[idx_prev(tail_q)];
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload; the words read as zero when the queue is empty.
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      front_q <= q_empty ? '0 : rd_front_q;
      back_q  <= q_empty ? '0 : rd_back_q;
      occ_q   <= cnt_q;
      empty_q <= q_empty;
      full_q  <= q_full;
      operr_q <= err_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_front_word_o = front_q;
  assign out_back_word_o  = back_q;
  assign out_occupancy_o  = occ_q;
  assign out_is_empty_o   = empty_q;
  assign out_is_full_o    = full_q;
  assign out_op_error_o   = operr_q;

  // Tail must always sit count slots past the head, modulo the capacity.
  logic [CNT_W:0]   idx_sum;
  logic [CNT_W:0]   idx_wrap;
  logic [IDX_W-1:0] tail_chk;

  assign idx_sum  = (CNT_W + 1)'(head_q) + (CNT_W + 1)'(cnt_q);
  assign idx_wrap = (idx_sum >= (CNT_W + 1)'(CAPACITY)) ?
                    idx_sum - (CNT_W + 1)'(CAPACITY) : idx_sum;
  assign tail_chk = idx_wrap[IDX_W-1:0];

  `DEQ_ASSERT(a_cnt_range, cnt_q <= CNT_W'(CAPACITY), "word count exceeds capacity")
  `DEQ_ASSERT(a_ring_consistent, tail_chk == tail_q, "tail index disagrees with head and count")
  `DEQ_ASSERT_NXT(a_busy_after_accept, in_accept, in_stall_o && state_q == ST_READ,
                  "input not stalled after an accepted beat")
  `DEQ_ASSERT_IMP(a_empty_words_zero, out_valid_o && out_is_empty_o,
                  out_front_word_o == '0 && out_back_word_o == '0 && !out_is_full_o,
                  "empty result carries nonzero words")

endmodule
